// ----- hw/rtl/fptm_pkg.sv -----
// Package: item types, operation and status codes, sequencer states.
package fptm_pkg;

    localparam int FLAG_BITS = 12;

    localparam logic [1:0] MODE_MAP    = 2'd0;
    localparam logic [1:0] MODE_UNMAP  = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;

    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_ABSENT  = 2'd1;
    localparam logic [1:0] STATUS_NO_ROOM = 2'd2;

    localparam int BIT_PRESENT = 0;
    localparam int BIT_WRITE   = 1;
    localparam int BIT_USER    = 2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [35:0] virt_page;
        logic [39:0] phys_page;
        logic [11:0] flags_in;
    } req_item_t;

    typedef struct packed {
        logic [39:0] found_page;
        logic [11:0] found_flags;
        logic [1:0]  status;
    } rsp_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_MAP_WR,
        ST_UNMAP_LEAF,
        ST_SCAN,
        ST_PARENT,
        ST_FINISH
    } state_t;

endpackage

// ----- hw/rtl/four_level_page_table_manager.sv -----
// Top level: four-level page table with map, unmap and lookup over one table RAM.
// One request item yields one response item. All table accesses go through a
// single RAM with one write and one registered read per cycle, which sets the
// timing. After reset the block clears the whole table store of TABLE_FRAMES *
// 2^INDEX_BITS entries (8192 by default), one entry per cycle, and holds
// req_stall high meanwhile. Map takes frames lowest first; a freed frame is
// always empty, so no clearing runs on allocation. Unmap walks, clears the
// leaf, then scans the three child tables of 2^INDEX_BITS entries each. A
// finished response waits in an output register while the next request is
// taken.
module four_level_page_table_manager #(
    parameter int INDEX_BITS   = 9,
    parameter int TABLE_FRAMES = 16,
    parameter int PAGE_BITS    = 40
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  fptm_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output fptm_pkg::rsp_item_t rsp
);

    import fptm_pkg::*;

    localparam int ENTRIES = 1 << INDEX_BITS;
    localparam int DEPTH   = TABLE_FRAMES * ENTRIES;
    localparam int AW      = $clog2(DEPTH);
    localparam int FW      = $clog2(TABLE_FRAMES);
    localparam int EW      = PAGE_BITS + FLAG_BITS;

    state_t state_reg, state_next;

    logic [AW-1:0]         clr_cnt_reg, clr_cnt_next;
    logic [1:0]            mode_reg, mode_next;
    logic [INDEX_BITS-1:0] idx_reg [4];
    logic [INDEX_BITS-1:0] idx_next [4];
    logic [PAGE_BITS-1:0]  page_reg, page_next;
    logic [11:0]           flags_reg, flags_next;
    logic [1:0]            lvl_reg, lvl_next;
    logic [1:0]            depth_reg, depth_next;
    logic [FW-1:0]         frame_reg [4];
    logic [FW-1:0]         frame_next [4];
    logic [EW-1:0]         ent_reg [4];
    logic [EW-1:0]         ent_next [4];
    logic [INDEX_BITS:0]   cnt_reg, cnt_next;
    logic [EW-1:0]         acc_reg, acc_next;
    logic                  scan_vld_reg, scan_vld_next;
    logic [TABLE_FRAMES-1:0] in_use_reg, in_use_next;
    logic [39:0]           res_page_reg, res_page_next;
    logic [11:0]           res_flags_reg, res_flags_next;
    logic [1:0]            res_status_reg, res_status_next;
    logic                  out_valid_reg, out_valid_next;
    rsp_item_t             out_item_reg, out_item_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;

    fptm_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Decode of the entry coming out of the RAM.
    logic                 child_ok;
    logic [FW-1:0]        child_frame;
    logic [PAGE_BITS-1:0] rd_page;
    logic [51:0]          rd_page_wide;
    logic [51:0]          phys_wide;
    logic [11:0]          keep;
    logic [FW-1:0]        low_free;
    int                   free_cnt;

    assign rd_page      = rdata[EW-1:FLAG_BITS];
    assign rd_page_wide = 52'(rd_page);
    assign child_frame  = rdata[FLAG_BITS +: FW];
    assign child_ok     = rdata[BIT_PRESENT] && (rd_page < PAGE_BITS'(TABLE_FRAMES));
    assign phys_wide    = 52'(req.phys_page);
    assign free_cnt     = $countones(~in_use_reg);

    always_comb
    begin
        keep              = '0;
        keep[BIT_WRITE]   = flags_reg[BIT_WRITE];
        keep[BIT_USER]    = flags_reg[BIT_USER];
        keep[BIT_PRESENT] = 1'b0;
    end

    always_comb
    begin
        low_free = '0;
        for (int f = TABLE_FRAMES - 1; f >= 1; f--)
        begin
            if (!in_use_reg[f])
            begin
                low_free = FW'(f);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            in_use_reg    <= TABLE_FRAMES'(1);
            out_valid_reg <= 1'b0;
            lvl_reg       <= '0;
            depth_reg     <= '0;
            cnt_reg       <= '0;
            scan_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            in_use_reg    <= in_use_next;
            out_valid_reg <= out_valid_next;
            lvl_reg       <= lvl_next;
            depth_reg     <= depth_next;
            cnt_reg       <= cnt_next;
            scan_vld_reg  <= scan_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        idx_reg        <= idx_next;
        page_reg       <= page_next;
        flags_reg      <= flags_next;
        frame_reg      <= frame_next;
        ent_reg        <= ent_next;
        acc_reg        <= acc_next;
        res_page_reg   <= res_page_next;
        res_flags_reg  <= res_flags_next;
        res_status_reg <= res_status_next;
        out_item_reg   <= out_item_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        mode_next       = mode_reg;
        idx_next        = idx_reg;
        page_next       = page_reg;
        flags_next      = flags_reg;
        lvl_next        = lvl_reg;
        depth_next      = depth_reg;
        frame_next      = frame_reg;
        ent_next        = ent_reg;
        cnt_next        = cnt_reg;
        acc_next        = acc_reg;
        scan_vld_next   = scan_vld_reg;
        in_use_next     = in_use_reg;
        res_page_next   = res_page_reg;
        res_flags_next  = res_flags_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        we              = 1'b0;
        waddr           = '0;
        wdata           = '0;
        raddr           = AW'({frame_reg[lvl_reg], idx_reg[lvl_reg]});
        req_stall       = (state_reg != ST_IDLE);

        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                we           = 1'b1;
                waddr        = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req_valid)
                begin
                    mode_next  = req.mode;
                    for (int k = 0; k < 4; k++)
                    begin
                        idx_next[k] = req.virt_page[(3 - k) * INDEX_BITS +: INDEX_BITS];
                    end
                    page_next       = phys_wide[PAGE_BITS-1:0];
                    flags_next      = req.flags_in;
                    frame_next[0]   = '0;
                    lvl_next        = '0;
                    res_page_next   = '0;
                    res_flags_next  = '0;
                    res_status_next = STATUS_DONE;
                    if (req.mode == MODE_MAP || req.mode == MODE_UNMAP
                        || req.mode == MODE_LOOKUP)
                    begin
                        state_next = ST_WALK_RD;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_WALK_RD:
            begin
                state_next = ST_WALK_CHK;
            end

            ST_WALK_CHK:
            begin
                if (mode_reg == MODE_LOOKUP && lvl_reg == 2'd3)
                begin
                    res_page_next  = rd_page_wide[39:0];
                    res_flags_next = rdata[FLAG_BITS-1:0];
                    state_next     = ST_FINISH;
                end
                else if (child_ok)
                begin
                    ent_next[lvl_reg]         = rdata;
                    frame_next[lvl_reg + 2'd1] = child_frame;
                    if (lvl_reg != 2'd2 || mode_reg == MODE_LOOKUP)
                    begin
                        lvl_next   = lvl_reg + 2'd1;
                        state_next = ST_WALK_RD;
                    end
                    else if (mode_reg == MODE_UNMAP)
                    begin
                        state_next = ST_UNMAP_LEAF;
                    end
                    else
                    begin
                        // Whole path present: no frames needed.
                        depth_next = 2'd3;
                        lvl_next   = '0;
                        state_next = ST_MAP_WR;
                    end
                end
                else if (mode_reg == MODE_MAP)
                begin
                    depth_next = lvl_reg;
                    lvl_next   = '0;
                    if (free_cnt >= 3 - int'(lvl_reg))
                    begin
                        state_next = ST_MAP_WR;
                    end
                    else
                    begin
                        res_status_next = STATUS_NO_ROOM;
                        state_next      = ST_FINISH;
                    end
                end
                else
                begin
                    res_status_next = STATUS_ABSENT;
                    state_next      = ST_FINISH;
                end
            end

            ST_MAP_WR:
            begin
                we    = 1'b1;
                waddr = AW'({frame_reg[lvl_reg], idx_reg[lvl_reg]});
                if (lvl_reg == 2'd3)
                begin
                    wdata      = {page_reg, flags_reg};
                    state_next = ST_FINISH;
                end
                else
                begin
                    if (lvl_reg < depth_reg)
                    begin
                        wdata = ent_reg[lvl_reg] | EW'(keep);
                    end
                    else
                    begin
                        // Freed frames are always empty, so a new table needs no clearing.
                        wdata                      = {PAGE_BITS'(low_free), keep};
                        wdata[BIT_PRESENT]         = 1'b1;
                        in_use_next[low_free]      = 1'b1;
                        frame_next[lvl_reg + 2'd1] = low_free;
                    end
                    lvl_next = lvl_reg + 2'd1;
                end
            end

            ST_UNMAP_LEAF:
            begin
                we            = 1'b1;
                waddr         = AW'({frame_reg[3], idx_reg[3]});
                lvl_next      = 2'd3;
                cnt_next      = '0;
                acc_next      = '0;
                scan_vld_next = 1'b0;
                state_next    = ST_SCAN;
            end

            ST_SCAN:
            begin
                raddr = AW'({frame_reg[lvl_reg], cnt_reg[INDEX_BITS-1:0]});
                if (scan_vld_reg)
                begin
                    acc_next = acc_reg | rdata;
                end
                if (cnt_reg == (INDEX_BITS + 1)'(ENTRIES))
                begin
                    scan_vld_next = 1'b0;
                    state_next    = ST_PARENT;
                end
                else
                begin
                    scan_vld_next = 1'b1;
                    cnt_next      = cnt_reg + 1'b1;
                end
            end

            ST_PARENT:
            begin
                we    = 1'b1;
                waddr = AW'({frame_reg[lvl_reg - 2'd1], idx_reg[lvl_reg - 2'd1]});
                if (acc_reg == '0)
                begin
                    // Drop the empty table and its parent entry.
                    wdata                          = '0;
                    in_use_next[frame_reg[lvl_reg]] = 1'b0;
                end
                else
                begin
                    wdata = ent_reg[lvl_reg - 2'd1];
                    if (!acc_reg[BIT_USER])
                    begin
                        wdata[BIT_USER] = 1'b0;
                    end
                    if (!acc_reg[BIT_WRITE])
                    begin
                        wdata[BIT_WRITE] = 1'b0;
                    end
                end
                if (lvl_reg == 2'd1)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    lvl_next      = lvl_reg - 2'd1;
                    cnt_next      = '0;
                    acc_next      = '0;
                    scan_vld_next = 1'b0;
                    state_next    = ST_SCAN;
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_valid_next            = 1'b1;
                    out_item_next.found_page  = res_page_reg;
                    out_item_next.found_flags = res_flags_reg;
                    out_item_next.status      = res_status_reg;
                    state_next                = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

endmodule

// ----- hw/rtl/fptm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fptm_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
